// ===== hdl/tcc_pkg.sv =====
// Shared types and constants of the TCP connection control block.
package tcc_pkg;

   // Command codes of an input beat
   localparam logic [1:0] CMD_SEGMENT = 2'd0;
   localparam logic [1:0] CMD_CONNECT = 2'd1;
   localparam logic [1:0] CMD_SEND    = 2'd2;
   localparam logic [1:0] CMD_CLOSE   = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_TRANSMIT = 2'd0;
   localparam logic [1:0] KIND_DELIVER  = 2'd1;
   localparam logic [1:0] KIND_REFUSE   = 2'd2;

   // Segment flag masks
   localparam logic [4:0] FLAG_FIN = 5'b00001;
   localparam logic [4:0] FLAG_SYN = 5'b00010;
   localparam logic [4:0] FLAG_RST = 5'b00100;
   localparam logic [4:0] FLAG_PSH = 5'b01000;
   localparam logic [4:0] FLAG_ACK = 5'b10000;

   // Connection states
   localparam logic [2:0] ST_CLOSED      = 3'd0;
   localparam logic [2:0] ST_SYN_SENT    = 3'd1;
   localparam logic [2:0] ST_ESTABLISHED = 3'd2;
   localparam logic [2:0] ST_FIN_WAIT1   = 3'd3;
   localparam logic [2:0] ST_FIN_WAIT2   = 3'd4;
   localparam logic [2:0] ST_CLOSE_WAIT  = 3'd5;
   localparam logic [2:0] ST_LAST_ACK    = 3'd6;
   localparam logic [2:0] ST_TIME_WAIT   = 3'd7;

   // Register map
   localparam logic [2:0] CSR_ADDR_ISS    = 3'd0;
   localparam logic [2:0] CSR_ADDR_WINDOW = 3'd4;

   localparam logic [31:0] ISS_RESET        = 32'd12345;
   localparam logic [15:0] WINDOW_RESET     = 16'd4096;
   localparam logic [15:0] EPHEMERAL_BASE   = 16'd49152;
   localparam logic [15:0] MIN_SEGMENT_LEN  = 16'd20;
   localparam int          RESULTS_PER_ITEM = 3;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] peer_address;
      logic [15:0] port;
      logic [9:0]  port_salt;
      logic [4:0]  seg_flags;
      logic [31:0] seg_sequence;
      logic [31:0] seg_acknowledge;
      logic [3:0]  header_words;
      logic [15:0] byte_length;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [4:0]  tx_flags;
      logic [31:0] tx_sequence;
      logic [31:0] tx_acknowledge;
      logic [15:0] tx_source_port;
      logic [15:0] tx_dest_port;
      logic [31:0] tx_dest_address;
      logic [15:0] payload_length;
      logic [5:0]  payload_offset;
      logic [2:0]  connection_state;
      logic        last;
   } result_type;

   // All results caused by one input beat
   typedef struct packed {
      logic [1:0]                        count;
      result_type [RESULTS_PER_ITEM-1:0] slot;
   } result_set_type;

endpackage

// ===== hdl/tcc_req_if.sv =====
// Command channel interface: valid/ready handshake with the command payload.
interface tcc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] peer_address;
   logic [15:0] port;
   logic [9:0]  port_salt;
   logic [4:0]  seg_flags;
   logic [31:0] seg_sequence;
   logic [31:0] seg_acknowledge;
   logic [3:0]  header_words;
   logic [15:0] byte_length;

   modport source (
      output valid, command, peer_address, port, port_salt, seg_flags,
             seg_sequence, seg_acknowledge, header_words, byte_length,
      input  ready
   );
   modport sink (
      input  valid, command, peer_address, port, port_salt, seg_flags,
             seg_sequence, seg_acknowledge, header_words, byte_length,
      output ready
   );
endinterface

// ===== hdl/tcc_rsp_if.sv =====
// Result channel interface: valid/ready handshake with the result payload.
interface tcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [4:0]  tx_flags;
   logic [31:0] tx_sequence;
   logic [31:0] tx_acknowledge;
   logic [15:0] tx_source_port;
   logic [15:0] tx_dest_port;
   logic [31:0] tx_dest_address;
   logic [15:0] payload_length;
   logic [5:0]  payload_offset;
   logic [2:0]  connection_state;
   logic        last;

   modport source (
      output valid, result_kind, tx_flags, tx_sequence, tx_acknowledge,
             tx_source_port, tx_dest_port, tx_dest_address, payload_length,
             payload_offset, connection_state, last,
      input  ready
   );
   modport sink (
      input  valid, result_kind, tx_flags, tx_sequence, tx_acknowledge,
             tx_source_port, tx_dest_port, tx_dest_address, payload_length,
             payload_offset, connection_state, last,
      output ready
   );
endinterface

// ===== hdl/tcc_csr.sv =====
// Configuration registers behind the APB-style port.
module tcc_csr
   import tcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] initial_send_sequence,
   output logic [15:0] advertised_window
);

   logic [31:0] iss_ff;
   logic [15:0] window_ff;
   logic        write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;

   // Register writes complete in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff    <= ISS_RESET;
         window_ff <= WINDOW_RESET;
      end else if (write_en) begin
         unique case (paddr)
            CSR_ADDR_ISS:    iss_ff    <= pwdata;
            CSR_ADDR_WINDOW: window_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read data is decoded straight from the address.
   always_comb begin
      unique case (paddr)
         CSR_ADDR_ISS:    prdata = iss_ff;
         CSR_ADDR_WINDOW: prdata = {16'd0, window_ff};
         default:         prdata = 32'd0;
      endcase
   end

   assign initial_send_sequence = iss_ff;
   assign advertised_window     = window_ff;

endmodule

// ===== hdl/tcc_engine.sv =====
// Connection state and the single-pass logic that turns one command into its results.
module tcc_engine
   import tcc_pkg::*;
#(
   parameter int MAX_SEND_PAYLOAD = 1024
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  req_item_type   item,
   input  logic [31:0]    initial_send_sequence,
   output result_set_type result_set
);

   logic [2:0]  state_ff, state_in;
   logic [31:0] remote_address_ff, remote_address_in;
   logic [15:0] peer_port_ff, peer_port_in;
   logic [15:0] own_port_ff, own_port_in;
   logic [31:0] send_next_ff, send_next_in;
   logic [31:0] send_unacked_ff, send_unacked_in;
   logic [31:0] receive_next_ff, receive_next_in;

   logic [5:0]  hdr_bytes;
   logic [15:0] seg_data_len;
   logic        seg_ok;
   logic        deliver;
   logic [31:0] rcv_after_data;
   logic [1:0]  n;
   result_type  res [RESULTS_PER_ITEM];

   // Transmit descriptor with the given addressing fields.
   function automatic result_type make_segment(
      input logic [4:0]  flags,
      input logic [31:0] seq,
      input logic [31:0] ack,
      input logic [15:0] sport,
      input logic [15:0] dport,
      input logic [31:0] daddr,
      input logic [15:0] plen
   );
      result_type r;
      r                 = '0;
      r.result_kind     = KIND_TRANSMIT;
      r.tx_flags        = flags;
      r.tx_sequence     = seq;
      r.tx_acknowledge  = ack;
      r.tx_source_port  = sport;
      r.tx_dest_port    = dport;
      r.tx_dest_address = daddr;
      r.payload_length  = plen;
      return r;
   endfunction

   function automatic result_type make_refusal();
      result_type r;
      r             = '0;
      r.result_kind = KIND_REFUSE;
      return r;
   endfunction

   // Segment checks and data length.
   assign hdr_bytes    = {item.header_words, 2'b00};
   assign seg_data_len = item.byte_length - {10'd0, hdr_bytes};
   assign seg_ok       = (item.byte_length >= MIN_SEGMENT_LEN)
                      && (item.peer_address == remote_address_ff)
                      && (item.port == own_port_ff)
                      && ({10'd0, hdr_bytes} <= item.byte_length);
   assign deliver      = (seg_data_len != 16'd0) && (item.seg_sequence == receive_next_ff);
   assign rcv_after_data = deliver ? receive_next_ff + {16'd0, seg_data_len}
                                   : receive_next_ff;

   // Next state and the ordered list of results.
   always_comb begin
      state_in          = state_ff;
      remote_address_in = remote_address_ff;
      peer_port_in      = peer_port_ff;
      own_port_in       = own_port_ff;
      send_next_in      = send_next_ff;
      send_unacked_in   = send_unacked_ff;
      receive_next_in   = receive_next_ff;
      n                 = 2'd0;
      for (int i = 0; i < RESULTS_PER_ITEM; i++) begin
         res[i] = '0;
      end

      unique case (item.command)
         CMD_SEGMENT: begin
            if (seg_ok) begin
               if ((item.seg_flags & FLAG_RST) != 5'd0) begin
                  state_in = ST_CLOSED;
               end else begin
                  unique case (state_ff) inside
                     ST_SYN_SENT: begin
                        if (((item.seg_flags & FLAG_SYN) != 5'd0)
                            && ((item.seg_flags & FLAG_ACK) != 5'd0)) begin
                           receive_next_in = item.seg_sequence + 32'd1;
                           send_unacked_in = item.seg_acknowledge;
                           state_in        = ST_ESTABLISHED;
                           res[0] = make_segment(FLAG_ACK, send_next_ff,
                                       item.seg_sequence + 32'd1, own_port_ff,
                                       peer_port_ff, remote_address_ff, 16'd0);
                           n = 2'd1;
                        end
                     end
                     ST_ESTABLISHED: begin
                        if ((item.seg_flags & FLAG_ACK) != 5'd0) begin
                           send_unacked_in = item.seg_acknowledge;
                        end
                        receive_next_in = rcv_after_data;
                        if (deliver) begin
                           res[0]                = '0;
                           res[0].result_kind    = KIND_DELIVER;
                           res[0].payload_length = seg_data_len;
                           res[0].payload_offset = hdr_bytes;
                           res[1] = make_segment(FLAG_ACK, send_next_ff, rcv_after_data,
                                       own_port_ff, peer_port_ff,
                                       remote_address_ff, 16'd0);
                           n = 2'd2;
                        end
                        if ((item.seg_flags & FLAG_FIN) != 5'd0) begin
                           receive_next_in = rcv_after_data + 32'd1;
                           res[n] = make_segment(FLAG_ACK, send_next_ff,
                                       rcv_after_data + 32'd1, own_port_ff,
                                       peer_port_ff, remote_address_ff, 16'd0);
                           n        = n + 2'd1;
                           state_in = ST_CLOSE_WAIT;
                        end
                     end
                     ST_FIN_WAIT1, ST_FIN_WAIT2: begin
                        if ((state_ff == ST_FIN_WAIT1)
                            && ((item.seg_flags & FLAG_ACK) != 5'd0)) begin
                           state_in = ST_FIN_WAIT2;
                        end
                        if ((item.seg_flags & FLAG_FIN) != 5'd0) begin
                           receive_next_in = receive_next_ff + 32'd1;
                           res[0] = make_segment(FLAG_ACK, send_next_ff,
                                       receive_next_ff + 32'd1, own_port_ff,
                                       peer_port_ff, remote_address_ff, 16'd0);
                           n        = 2'd1;
                           state_in = ST_TIME_WAIT;
                        end
                     end
                     ST_LAST_ACK: begin
                        if ((item.seg_flags & FLAG_ACK) != 5'd0) begin
                           state_in = ST_CLOSED;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         CMD_CONNECT: begin
            if (state_ff != ST_CLOSED) begin
               res[0] = make_refusal();
               n      = 2'd1;
            end else begin
               remote_address_in = item.peer_address;
               peer_port_in      = item.port;
               own_port_in       = EPHEMERAL_BASE + {6'd0, item.port_salt};
               send_next_in      = initial_send_sequence + 32'd1;
               send_unacked_in   = initial_send_sequence;
               receive_next_in   = 32'd0;
               state_in          = ST_SYN_SENT;
               res[0] = make_segment(FLAG_SYN, initial_send_sequence, 32'd0,
                           EPHEMERAL_BASE + {6'd0, item.port_salt}, item.port,
                           item.peer_address, 16'd0);
               n = 2'd1;
            end
         end
         CMD_SEND: begin
            if ((state_ff != ST_ESTABLISHED)
                || (item.byte_length > 16'(MAX_SEND_PAYLOAD))) begin
               res[0] = make_refusal();
            end else begin
               res[0] = make_segment(FLAG_ACK | FLAG_PSH, send_next_ff, receive_next_ff,
                           own_port_ff, peer_port_ff, remote_address_ff,
                           item.byte_length);
               send_next_in = send_next_ff + {16'd0, item.byte_length};
            end
            n = 2'd1;
         end
         CMD_CLOSE: begin
            if ((state_ff == ST_ESTABLISHED) || (state_ff == ST_CLOSE_WAIT)) begin
               res[0] = make_segment(FLAG_ACK | FLAG_FIN, send_next_ff, receive_next_ff,
                           own_port_ff, peer_port_ff, remote_address_ff, 16'd0);
               send_next_in = send_next_ff + 32'd1;
               state_in     = (state_ff == ST_ESTABLISHED) ? ST_FIN_WAIT1 : ST_LAST_ACK;
            end else begin
               res[0] = make_refusal();
            end
            n = 2'd1;
         end
         default: ;
      endcase

      // Every result carries the final state; the last one is marked.
      result_set.count = n;
      for (int i = 0; i < RESULTS_PER_ITEM; i++) begin
         res[i].connection_state = state_in;
         res[i].last             = (2'(i) == n - 2'd1);
         result_set.slot[i]      = res[i];
      end
   end

   // Connection state registers, updated once per fired command.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLOSED;
         remote_address_ff <= 32'd0;
         peer_port_ff      <= 16'd0;
         own_port_ff       <= 16'd0;
         send_next_ff      <= 32'd0;
         send_unacked_ff   <= 32'd0;
         receive_next_ff   <= 32'd0;
      end else if (fire) begin
         state_ff          <= state_in;
         remote_address_ff <= remote_address_in;
         peer_port_ff      <= peer_port_in;
         own_port_ff       <= own_port_in;
         send_next_ff      <= send_next_in;
         send_unacked_ff   <= send_unacked_in;
         receive_next_ff   <= receive_next_in;
      end
   end

endmodule

// ===== hdl/tcc_result_buffer.sv =====
// Result register that holds one command's results and hands them out one beat at a time.
module tcc_result_buffer
   import tcc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  result_set_type result_set,
   output logic           free,
   tcc_rsp_if.source      rsp_chan
);

   result_set_type set_ff;
   logic           valid_ff;
   logic [1:0]     idx_ff;
   logic           pop;
   logic           on_last;
   result_type     cur;

   assign pop     = valid_ff && rsp_chan.ready;
   assign on_last = (idx_ff == set_ff.count - 2'd1);
   assign free    = !valid_ff || (pop && on_last);

   // Hold a result set until its last beat has been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load && (result_set.count != 2'd0)) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (pop && on_last) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         set_ff <= result_set;
      end
   end

   // Present the current slot on the result channel.
   assign cur                       = set_ff.slot[idx_ff];
   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.result_kind      = cur.result_kind;
   assign rsp_chan.tx_flags         = cur.tx_flags;
   assign rsp_chan.tx_sequence      = cur.tx_sequence;
   assign rsp_chan.tx_acknowledge   = cur.tx_acknowledge;
   assign rsp_chan.tx_source_port   = cur.tx_source_port;
   assign rsp_chan.tx_dest_port     = cur.tx_dest_port;
   assign rsp_chan.tx_dest_address  = cur.tx_dest_address;
   assign rsp_chan.payload_length   = cur.payload_length;
   assign rsp_chan.payload_offset   = cur.payload_offset;
   assign rsp_chan.connection_state = cur.connection_state;
   assign rsp_chan.last             = cur.last;

endmodule

// ===== hdl/tcp_connection_control_core.sv =====
// Top level of the single-connection TCP control block.
//
// Commands (received segment header, connect, send, close) arrive as beats on
// req_chan; descriptors to transmit, delivery notices and refusals leave as
// beats on rsp_chan, one to three per command, the final one marked by last.
// A command with no effect on the peer (a discarded segment, a reset, an
// ignored segment) gives no beat at all.
// A command beat is taken into an input register, processed against the
// connection state once the result register is free, and written with all
// its results into the result register, from which they are offered in order.
// One command per cycle is taken while each yields at most one result and the
// receiver keeps ready high; a command with more results holds the result
// register until its last is taken, which sets the rate when results pile up.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more command, after which req_chan.ready falls.
// Reset clears the connection to closed with zero addresses, ports and
// sequence numbers, empties both registers, and restores the initial send
// sequence (12345) and advertised window (4096). The user must write registers
// over the APB-style port only while the block is idle; the block does not enforce it.
module tcp_connection_control_core
   import tcc_pkg::*;
#(
   parameter int MAX_SEND_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   tcc_req_if.sink     req_chan,
   tcc_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   req_item_type   item_ff;
   logic           in_valid_ff;
   logic           fire;
   logic           buf_free;
   logic           accept;
   logic [31:0]    initial_send_sequence;
   logic [15:0]    advertised_window;
   result_set_type result_set;

   // Input register: refilled as soon as its command is processed.
   assign fire           = in_valid_ff && buf_free;
   assign req_chan.ready = !in_valid_ff || fire;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.command         <= req_chan.command;
         item_ff.peer_address    <= req_chan.peer_address;
         item_ff.port            <= req_chan.port;
         item_ff.port_salt       <= req_chan.port_salt;
         item_ff.seg_flags       <= req_chan.seg_flags;
         item_ff.seg_sequence    <= req_chan.seg_sequence;
         item_ff.seg_acknowledge <= req_chan.seg_acknowledge;
         item_ff.header_words    <= req_chan.header_words;
         item_ff.byte_length     <= req_chan.byte_length;
      end
   end

   tcc_csr u_csr (
      .clock                 (clock),
      .reset                 (reset),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready),
      .initial_send_sequence (initial_send_sequence),
      .advertised_window     (advertised_window)
   );

   tcc_engine #(
      .MAX_SEND_PAYLOAD (MAX_SEND_PAYLOAD)
   ) u_engine (
      .clock                 (clock),
      .reset                 (reset),
      .fire                  (fire),
      .item                  (item_ff),
      .initial_send_sequence (initial_send_sequence),
      .result_set            (result_set)
   );

   tcc_result_buffer u_result_buffer (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result_set (result_set),
      .free       (buf_free),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== test/tcp_connection_control_core_test.sv =====
// Self-checking testbench for the TCP connection control block, with its own connection predictor.
module tcp_connection_control_core_test;
   import tcc_pkg::*;

   localparam int SEND_PAYLOAD_LIMIT = 1024;
   localparam int CYCLE_LIMIT        = 200000;
   localparam int PHASE_ITEMS        = 100;
   localparam int LONG_HOLD_CYCLES   = 120;
   localparam int DRAIN_CYCLES       = 6;

   // Expected result beats, worked out from every accepted command beat.
   class tcc_scoreboard;
      logic [31:0] initial_sequence;
      logic [15:0] window;
      logic [2:0]  link_state;
      logic [31:0] remote_address;
      logic [15:0] peer_port;
      logic [15:0] own_port;
      logic [31:0] send_next;
      logic [31:0] send_unacked;
      logic [31:0] receive_next;
      result_type  expected_results[$];
      result_type  batch[$];
      int          failures;

      function new();
         initial_sequence = ISS_RESET;
         window           = WINDOW_RESET;
         link_state       = ST_CLOSED;
         remote_address   = '0;
         peer_port        = '0;
         own_port         = '0;
         send_next        = '0;
         send_unacked     = '0;
         receive_next     = '0;
         failures         = 0;
      endfunction

      function void write_register(logic [2:0] addr, logic [31:0] value);
         if (addr == CSR_ADDR_ISS) initial_sequence = value;
         else if (addr == CSR_ADDR_WINDOW) window = value[15:0];
      endfunction

      function void add_segment(logic [4:0] flags, logic [15:0] len);
         result_type r;
         r = '0;
         r.result_kind     = KIND_TRANSMIT;
         r.tx_flags        = flags;
         r.tx_sequence     = send_next;
         r.tx_acknowledge  = receive_next;
         r.tx_source_port  = own_port;
         r.tx_dest_port    = peer_port;
         r.tx_dest_address = remote_address;
         r.payload_length  = len;
         batch.push_back(r);
      endfunction

      function void add_delivery(logic [15:0] len, logic [5:0] offset);
         result_type r;
         r = '0;
         r.result_kind    = KIND_DELIVER;
         r.payload_length = len;
         r.payload_offset = offset;
         batch.push_back(r);
      endfunction

      function void add_refusal();
         result_type r;
         r = '0;
         r.result_kind = KIND_REFUSE;
         batch.push_back(r);
      endfunction

      // The peer's FIN is taken whatever its sequence number.
      function void take_fin(logic [2:0] next_state);
         receive_next = receive_next + 32'd1;
         add_segment(FLAG_ACK, 16'd0);
         link_state = next_state;
      endfunction

      function void take_segment(req_item_type c);
         logic [15:0] header_bytes;
         logic [15:0] payload_bytes;
         header_bytes = {10'd0, c.header_words, 2'b00};
         if (c.byte_length < MIN_SEGMENT_LEN || c.peer_address != remote_address ||
             c.port != own_port || header_bytes > c.byte_length) return;
         payload_bytes = c.byte_length - header_bytes;
         if (|(c.seg_flags & FLAG_RST)) begin
            link_state = ST_CLOSED;
            return;
         end
         case (link_state)
            ST_SYN_SENT: begin
               if (|(c.seg_flags & FLAG_SYN) && |(c.seg_flags & FLAG_ACK)) begin
                  receive_next = c.seg_sequence + 32'd1;
                  send_unacked = c.seg_acknowledge;
                  link_state   = ST_ESTABLISHED;
                  add_segment(FLAG_ACK, 16'd0);
               end
            end
            ST_ESTABLISHED: begin
               if (|(c.seg_flags & FLAG_ACK)) send_unacked = c.seg_acknowledge;
               if (payload_bytes != 16'd0 && c.seg_sequence == receive_next) begin
                  receive_next = receive_next + {16'd0, payload_bytes};
                  add_delivery(payload_bytes, header_bytes[5:0]);
                  add_segment(FLAG_ACK, 16'd0);
               end
               if (|(c.seg_flags & FLAG_FIN)) take_fin(ST_CLOSE_WAIT);
            end
            ST_FIN_WAIT1: begin
               if (|(c.seg_flags & FLAG_ACK)) link_state = ST_FIN_WAIT2;
               if (|(c.seg_flags & FLAG_FIN)) take_fin(ST_TIME_WAIT);
            end
            ST_FIN_WAIT2: begin
               if (|(c.seg_flags & FLAG_FIN)) take_fin(ST_TIME_WAIT);
            end
            ST_LAST_ACK: begin
               if (|(c.seg_flags & FLAG_ACK)) link_state = ST_CLOSED;
            end
            default: ;
         endcase
      endfunction

      function void note_command(req_item_type c);
         batch.delete();
         case (c.command)
            CMD_SEGMENT: take_segment(c);
            CMD_CONNECT: begin
               if (link_state != ST_CLOSED) begin
                  add_refusal();
               end else begin
                  remote_address = c.peer_address;
                  peer_port      = c.port;
                  own_port       = EPHEMERAL_BASE + {6'd0, c.port_salt};
                  send_next      = initial_sequence;
                  send_unacked   = initial_sequence;
                  receive_next   = '0;
                  link_state     = ST_SYN_SENT;
                  add_segment(FLAG_SYN, 16'd0);
                  send_next = send_next + 32'd1;
               end
            end
            CMD_SEND: begin
               if (link_state != ST_ESTABLISHED || int'(c.byte_length) > SEND_PAYLOAD_LIMIT) begin
                  add_refusal();
               end else begin
                  add_segment(FLAG_ACK | FLAG_PSH, c.byte_length);
                  send_next = send_next + {16'd0, c.byte_length};
               end
            end
            default: begin
               if (link_state == ST_ESTABLISHED || link_state == ST_CLOSE_WAIT) begin
                  add_segment(FLAG_ACK | FLAG_FIN, 16'd0);
                  send_next  = send_next + 32'd1;
                  link_state = (link_state == ST_ESTABLISHED) ? ST_FIN_WAIT1 : ST_LAST_ACK;
               end else begin
                  add_refusal();
               end
            end
         endcase
         // Every beat carries the state after the whole command; the final one is marked.
         foreach (batch[k]) begin
            batch[k].connection_state = link_state;
            batch[k].last             = (k == batch.size() - 1);
            expected_results.push_back(batch[k]);
         end
      endfunction

      function string describe(result_type r);
         return $sformatf({"kind %0d flags %02h seq %08h ack %08h sport %04h dport %04h ",
                           "addr %08h len %0d off %0d state %0d last %0d"},
                          r.result_kind, r.tx_flags, r.tx_sequence, r.tx_acknowledge,
                          r.tx_source_port, r.tx_dest_port, r.tx_dest_address,
                          r.payload_length, r.payload_offset, r.connection_state, r.last);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10) $display("result beat with nothing expected: %s", describe(got));
            return;
         end
         want = expected_results.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("result beat mismatch");
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   tcc_req_if req_bus ();
   tcc_rsp_if rsp_bus ();

   tcc_scoreboard sb;
   bit            hold_request;
   int            burst_left;
   int            cycle_count;

   tcp_connection_control_core #(
      .MAX_SEND_PAYLOAD(SEND_PAYLOAD_LIMIT)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The run is abandoned if it takes far longer than the slowest correct run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Result receiver: changing stall patterns, plus a long hold-off on request.
   initial begin
      int   mode;
      int   mode_left;
      int   hold_left;
      int   pattern_count;
      logic next_ready;
      mode          = 0;
      mode_left     = 0;
      hold_left     = 0;
      pattern_count = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         pattern_count++;
         case (mode)
            0:       next_ready = 1'b1;
            1:       next_ready = 1'($urandom_range(0, 1));
            2:       next_ready = ($urandom_range(0, 3) == 0);
            default: next_ready = (pattern_count % 5) < 3;
         endcase
         if (hold_left > 0) begin
            next_ready = 1'b0;
            hold_left--;
         end
         rsp_bus.ready <= next_ready;
      end
   end

   // Every result beat taken by the receiver is checked against the oldest expectation.
   initial begin
      result_type got;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.result_kind      = rsp_bus.result_kind;
            got.tx_flags         = rsp_bus.tx_flags;
            got.tx_sequence      = rsp_bus.tx_sequence;
            got.tx_acknowledge   = rsp_bus.tx_acknowledge;
            got.tx_source_port   = rsp_bus.tx_source_port;
            got.tx_dest_port     = rsp_bus.tx_dest_port;
            got.tx_dest_address  = rsp_bus.tx_dest_address;
            got.payload_length   = rsp_bus.payload_length;
            got.payload_offset   = rsp_bus.payload_offset;
            got.connection_state = rsp_bus.connection_state;
            got.last             = rsp_bus.last;
            sb.check_result(got);
         end
      end
   end

   // Offers one command beat, after a random gap at the start of each burst,
   // and records it once the block has taken it.
   task automatic offer_command(req_item_type c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid           <= 1'b1;
      req_bus.command         <= c.command;
      req_bus.peer_address    <= c.peer_address;
      req_bus.port            <= c.port;
      req_bus.port_salt       <= c.port_salt;
      req_bus.seg_flags       <= c.seg_flags;
      req_bus.seg_sequence    <= c.seg_sequence;
      req_bus.seg_acknowledge <= c.seg_acknowledge;
      req_bus.header_words    <= c.header_words;
      req_bus.byte_length     <= c.byte_length;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_command(c);
   endtask

   // Stops offering and waits until every expected beat is in, plus the pipeline depth
   // for commands that give no beat at all.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] addr, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_register(addr, value);
      @(posedge clock);
   endtask

   function automatic req_item_type make_command(logic [1:0] cmd, logic [31:0] addr,
                                                 logic [15:0] port, logic [9:0] salt,
                                                 logic [15:0] len);
      req_item_type c;
      c              = '0;
      c.command      = cmd;
      c.peer_address = addr;
      c.port         = port;
      c.port_salt    = salt;
      c.byte_length  = len;
      return c;
   endfunction

   function automatic req_item_type make_segment(logic [31:0] addr, logic [15:0] port,
                                                 logic [4:0] flags, logic [31:0] seq,
                                                 logic [31:0] ack, logic [3:0] words,
                                                 logic [15:0] len);
      req_item_type c;
      c                 = make_command(CMD_SEGMENT, addr, port, 10'd0, len);
      c.seg_flags       = flags;
      c.seg_sequence    = seq;
      c.seg_acknowledge = ack;
      c.header_words    = words;
      return c;
   endfunction

   function automatic req_item_type noise_command();
      req_item_type c;
      c.command         = 2'($urandom_range(0, 3));
      c.peer_address    = $urandom;
      c.port            = 16'($urandom_range(0, 65535));
      c.port_salt       = 10'($urandom_range(0, 1023));
      c.seg_flags       = 5'($urandom_range(0, 31));
      c.seg_sequence    = $urandom;
      c.seg_acknowledge = $urandom;
      c.header_words    = 4'($urandom_range(0, 15));
      c.byte_length     = 16'($urandom_range(0, 65535));
      return c;
   endfunction

   // A segment from the current peer to the current local port, now and then
   // broken so that one of the acceptance checks throws it away.
   function automatic req_item_type peer_segment(logic [4:0] flags, logic [31:0] seq,
                                                 int payload_bytes);
      req_item_type c;
      int           words;
      int           total;
      c              = noise_command();
      c.command      = CMD_SEGMENT;
      c.peer_address = sb.remote_address;
      c.port         = sb.own_port;
      c.seg_flags    = flags;
      c.seg_sequence = seq;
      words          = $urandom_range(0, 15);
      total          = words * 4 + payload_bytes;
      if (total < 20) total = 20;
      c.header_words = 4'(words);
      c.byte_length  = 16'(total);
      case ($urandom_range(0, 24))
         0: c.byte_length = 16'($urandom_range(0, 19));
         1: c.peer_address = c.peer_address ^ (32'd1 << $urandom_range(0, 31));
         2: c.port = c.port ^ (16'd1 << $urandom_range(0, 15));
         3: begin
            c.header_words = 4'd15;
            c.byte_length  = 16'($urandom_range(20, 59));
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic logic [4:0] flags_without_reset();
      return 5'($urandom_range(0, 31)) & ~FLAG_RST;
   endfunction

   // Mostly commands that move the connection on from its present state.
   function automatic req_item_type random_command();
      req_item_type c;
      int           pick;
      logic [4:0]   flags;
      c    = noise_command();
      pick = $urandom_range(0, 99);
      if (pick < 12) return c;
      case (sb.link_state) inside
         ST_CLOSED: begin
            if (pick < 80) c.command = CMD_CONNECT;
            else c = peer_segment(5'($urandom_range(0, 31)), $urandom, $urandom_range(0, 100));
         end
         ST_SYN_SENT: begin
            if (pick < 85) begin
               flags = FLAG_SYN | FLAG_ACK | (5'($urandom_range(0, 31)) & (FLAG_FIN | FLAG_PSH));
               c = peer_segment(flags, $urandom, $urandom_range(0, 40));
            end else begin
               c = peer_segment(5'($urandom_range(0, 31)), $urandom, $urandom_range(0, 40));
            end
         end
         ST_ESTABLISHED: begin
            flags = (($urandom_range(0, 7) != 0) ? FLAG_ACK : 5'd0) |
                    (($urandom_range(0, 1) != 0) ? FLAG_PSH : 5'd0);
            if (pick < 40) begin
               if ($urandom_range(0, 7) == 0) flags = flags | FLAG_FIN;
               c = peer_segment(flags, sb.receive_next, $urandom_range(0, 300));
            end else if (pick < 50) begin
               c = peer_segment(flags, sb.receive_next + 32'($urandom_range(1, 1000)),
                                $urandom_range(1, 300));
            end else if (pick < 78) begin
               c.command = CMD_SEND;
               case ($urandom_range(0, 9))
                  0:       c.byte_length = 16'($urandom_range(SEND_PAYLOAD_LIMIT + 1, 65535));
                  1:       c.byte_length = 16'(SEND_PAYLOAD_LIMIT);
                  2:       c.byte_length = 16'd0;
                  default: c.byte_length = 16'($urandom_range(0, SEND_PAYLOAD_LIMIT));
               endcase
            end else if (pick < 86) begin
               c.command = CMD_CLOSE;
            end else if (pick < 96) begin
               c = peer_segment(flags | FLAG_FIN, $urandom, $urandom_range(0, 20));
            end else begin
               c = peer_segment(5'($urandom_range(0, 31)) | FLAG_RST, $urandom, 0);
            end
         end
         ST_FIN_WAIT1, ST_FIN_WAIT2: begin
            case ($urandom_range(0, 3))
               0:       flags = FLAG_ACK;
               1:       flags = FLAG_FIN;
               2:       flags = FLAG_ACK | FLAG_FIN;
               default: flags = flags_without_reset();
            endcase
            if (pick < 90) c = peer_segment(flags, $urandom, $urandom_range(0, 40));
         end
         ST_CLOSE_WAIT: begin
            if (pick < 60) c.command = CMD_CLOSE;
            else if (pick < 80) c = peer_segment(flags_without_reset(), $urandom, 20);
         end
         ST_LAST_ACK: begin
            if (pick < 70) c = peer_segment(FLAG_ACK | (flags_without_reset() & FLAG_PSH),
                                            $urandom, $urandom_range(0, 40));
            else if (pick < 85) c = peer_segment(flags_without_reset(), $urandom, 20);
         end
         default: begin
            // Time wait is left only through a reset from the peer.
            if (pick < 60) c = peer_segment(FLAG_RST | 5'($urandom_range(0, 31)), $urandom, 0);
            else if (pick < 80) c.command = CMD_CONNECT;
         end
      endcase
      return c;
   endfunction

   // Main sequence: reset, directed commands, then random phases under several settings.
   initial begin
      logic [31:0] iss_value;
      logic [15:0] window_value;
      logic [15:0] high_port;
      sb                      = new();
      hold_request            = 1'b0;
      burst_left              = 0;
      reset                   = 1'b1;
      psel                    = 1'b0;
      penable                 = 1'b0;
      pwrite                  = 1'b0;
      paddr                   = '0;
      pwdata                  = '0;
      req_bus.valid           = 1'b0;
      req_bus.command         = CMD_SEGMENT;
      req_bus.peer_address    = '0;
      req_bus.port            = '0;
      req_bus.port_salt       = '0;
      req_bus.seg_flags       = '0;
      req_bus.seg_sequence    = '0;
      req_bus.seg_acknowledge = '0;
      req_bus.header_words    = '0;
      req_bus.byte_length     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Refusals and an ignored segment with the connection closed.
      high_port = EPHEMERAL_BASE + 16'd1023;
      offer_command(make_command(CMD_SEND, 32'd0, 16'd0, 10'd0, 16'd10));
      offer_command(make_command(CMD_CLOSE, 32'd0, 16'd0, 10'd0, 16'd0));
      offer_command(make_segment(32'd0, 16'd0, FLAG_ACK, 32'd0, 32'd0, 4'd5, 16'd20));
      // Open to the highest address and port, then a refused second connect.
      offer_command(make_command(CMD_CONNECT, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 16'd0));
      offer_command(make_command(CMD_CONNECT, 32'd0, 16'd0, 10'd0, 16'd0));
      // Segments thrown away: too short, wrong peer, wrong port, header past the end.
      offer_command(make_segment(32'hFFFF_FFFF, high_port, FLAG_SYN | FLAG_ACK,
                                 32'd1, 32'd1, 4'd0, 16'd19));
      offer_command(make_segment(32'hFFFF_FFFE, high_port, FLAG_SYN | FLAG_ACK,
                                 32'd1, 32'd1, 4'd5, 16'd20));
      offer_command(make_segment(32'hFFFF_FFFF, high_port - 16'd1, FLAG_SYN | FLAG_ACK,
                                 32'd1, 32'd1, 4'd5, 16'd20));
      offer_command(make_segment(32'hFFFF_FFFF, high_port, FLAG_SYN | FLAG_ACK,
                                 32'd1, 32'd1, 4'd15, 16'd59));
      // Handshake with the peer sequence at its top, so receive-next wraps.
      offer_command(make_segment(32'hFFFF_FFFF, high_port, FLAG_SYN | FLAG_ACK,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd5, 16'd20));
      // Sends: empty, at the limit, just over it, and the largest length.
      offer_command(make_command(CMD_SEND, 32'd0, 16'd0, 10'd0, 16'd0));
      offer_command(make_command(CMD_SEND, 32'd0, 16'd0, 10'd0, 16'(SEND_PAYLOAD_LIMIT)));
      offer_command(make_command(CMD_SEND, 32'd0, 16'd0, 10'd0,
                                 16'(SEND_PAYLOAD_LIMIT + 1)));
      offer_command(make_command(CMD_SEND, 32'd0, 16'd0, 10'd0, 16'hFFFF));
      // Out-of-order data, then in-order data with FIN at the largest sizes.
      offer_command(make_segment(32'hFFFF_FFFF, high_port, FLAG_ACK,
                                 32'd5, 32'h0000_1234, 4'd5, 16'd30));
      offer_command(make_segment(32'hFFFF_FFFF, high_port, FLAG_ACK | FLAG_PSH | FLAG_FIN,
                                 32'd0, 32'hFFFF_FFFF, 4'd15, 16'hFFFF));
      // Close wait: segments ignored, send refused, close goes to last ack.
      offer_command(make_segment(32'hFFFF_FFFF, high_port, FLAG_ACK | FLAG_FIN,
                                 32'd0, 32'd0, 4'd5, 16'd40));
      offer_command(make_command(CMD_SEND, 32'd0, 16'd0, 10'd0, 16'd1));
      offer_command(make_command(CMD_CLOSE, 32'd0, 16'd0, 10'd0, 16'd0));
      offer_command(make_segment(32'hFFFF_FFFF, high_port, FLAG_ACK,
                                 32'd0, 32'd0, 4'd5, 16'd20));
      // Second connection at the lowest values; we close first and the peer's FIN
      // arrives without an ACK, taken regardless of its sequence number.
      offer_command(make_command(CMD_CONNECT, 32'd0, 16'd0, 10'd0, 16'd0));
      offer_command(make_segment(32'd0, EPHEMERAL_BASE, FLAG_SYN | FLAG_ACK,
                                 32'h1234_5678, 32'd0, 4'd0, 16'd20));
      offer_command(make_command(CMD_CLOSE, 32'd0, 16'd0, 10'd0, 16'd0));
      offer_command(make_segment(32'd0, EPHEMERAL_BASE, FLAG_FIN,
                                 32'hDEAD_BEEF, 32'd0, 4'd5, 16'd20));
      offer_command(make_command(CMD_CONNECT, 32'd0, 16'd0, 10'd0, 16'd0));
      offer_command(make_command(CMD_CLOSE, 32'd0, 16'd0, 10'd0, 16'd0));
      offer_command(make_segment(32'd0, EPHEMERAL_BASE, FLAG_RST,
                                 32'd0, 32'd0, 4'd5, 16'd20));
      drain_results();

      // Random phases, each under its own register setting.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               iss_value    = 32'd0;
               window_value = 16'd0;
            end
            1: begin
               iss_value    = 32'hFFFF_FFFF;
               window_value = 16'hFFFF;
            end
            2: begin
               iss_value    = $urandom;
               window_value = 16'($urandom_range(0, 65535));
            end
            default: begin
               iss_value    = 32'hFFFF_FFF0;
               window_value = 16'($urandom_range(0, 65535));
            end
         endcase
         write_csr(CSR_ADDR_ISS, iss_value);
         write_csr(CSR_ADDR_WINDOW, {16'd0, window_value});
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // A long receiver hold-off while the sender keeps offering.
            if (i == 40 && (p == 0 || p == 2)) hold_request = 1'b1;
            offer_command(random_command());
         end
         drain_results();
      end

      if (sb.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tcc_pkg.sv
hdl/tcc_req_if.sv
hdl/tcc_rsp_if.sv
hdl/tcc_csr.sv
hdl/tcc_engine.sv
hdl/tcc_result_buffer.sv
hdl/tcp_connection_control_core.sv
test/tcp_connection_control_core_test.sv
